[rtl/shi_pkg.sv]
`timescale 1ns / 1ps
package shi_pkg;
  localparam int unsigned Lanes = 2;
  localparam int unsigned RegBits = 8;
  localparam int unsigned AgeBits = 32;
  localparam int unsigned LaneW = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int unsigned CntW = $clog2(Lanes + 1);

  localparam logic CfgMemFwd = 1'b0;
  localparam logic CfgExeFwd = 1'b1;

  typedef logic [RegBits-1:0] reg_t;
  typedef logic [AgeBits-1:0] age_t;

  // One pipeline latch entry
  typedef struct packed {
    logic valid;
    logic stall;
    logic load;
    logic misp;
    logic src1;
    logic src2;
    logic dest;
    logic ccr;
    logic ccw;
    reg_t r1;
    reg_t r2;
    reg_t rd;
    age_t age;
  } entry_t;

  // Input item
  typedef struct packed {
    logic [1:0]  present;
    logic [1:0]  is_load;
    logic [1:0]  misp;
    logic [1:0]  src1_used;
    logic [1:0]  src2_used;
    logic [1:0]  dest_used;
    logic [1:0]  cc_reads;
    logic [1:0]  cc_writes;
    logic [15:0] src1_regs;
    logic [15:0] src2_regs;
    logic [15:0] dest_regs;
  } item_t;

  // Result item
  typedef struct packed {
    logic [1:0] records_taken;
    logic [1:0] decode_stall_mask;
    logic [1:0] retired_count;
    logic       fetch_blocked;
  } result_t;

  // Per-lane hazard verdict handed to the merge
  typedef struct packed {
    logic       id_valid;
    logic       prim;
    logic [Lanes-1:0] older_than;
  } lane_stat_t;

  function automatic logic younger(age_t a, age_t b);
    age_t d;
    d = a - b;
    return (d != '0) && !d[AgeBits-1];
  endfunction

  function automatic logic [2:0] hazards(entry_t c, entry_t p);
    logic [2:0] h;
    h = '0;
    if (p.valid) begin
      h[0] = c.src1 && p.dest && (c.r1 == p.rd);
      h[1] = c.src2 && p.dest && (c.r2 == p.rd);
      h[2] = c.ccr && p.ccw;
    end
    return h;
  endfunction
endpackage

[rtl/shi_if.sv]
`timescale 1ns / 1ps
interface shi_in_if;
  logic valid;
  logic ready;
  shi_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shi_out_if;
  logic valid;
  logic ready;
  shi_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface shi_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [0:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/shi_lane.sv]
`timescale 1ns / 1ps
// Hazard check of one decode lane against MA, EX and the older decode lanes
module shi_lane (
  input  logic [shi_pkg::LaneW-1:0]        lane_i,
  input  shi_pkg::entry_t [shi_pkg::Lanes-1:0] id_i,
  input  shi_pkg::entry_t [shi_pkg::Lanes-1:0] ex_i,
  input  shi_pkg::entry_t [shi_pkg::Lanes-1:0] ma_i,
  input  logic                             mem_fwd_i,
  input  logic                             exe_fwd_i,
  output shi_pkg::lane_stat_t              stat_o
);
  import shi_pkg::*;

  entry_t cons;
  logic   st;
  logic [2:0] h;
  logic [2:0] have;
  logic [LaneW-1:0] best [3];
  logic [Lanes-1:0] older;

  assign cons = id_i[lane_i];

  // Collect hazards; under execute forwarding track youngest EX producer
  always_comb begin
    st = 1'b0;
    have = '0;
    h = '0;
    for (int t = 0; t < 3; t++) best[t] = '0;
    for (int j = 0; j < Lanes; j++) begin
      if (!mem_fwd_i && (hazards(cons, ma_i[j]) != '0)) st = 1'b1;
      h = hazards(cons, ex_i[j]);
      if (exe_fwd_i) begin
        for (int t = 0; t < 3; t++) begin
          if (h[t] && (!have[t] || younger(ex_i[j].age, ex_i[best[t]].age))) begin
            have[t] = 1'b1;
            best[t] = LaneW'(j);
          end
        end
      end else if (h != '0) begin
        st = 1'b1;
      end
      if (id_i[j].valid && younger(cons.age, id_i[j].age) &&
          (hazards(cons, id_i[j]) != '0)) st = 1'b1;
    end
    if (exe_fwd_i) begin
      for (int t = 0; t < 3; t++)
        if (have[t] && ex_i[best[t]].load) st = 1'b1;
    end
  end

  // Mark lanes younger than this one, for stall spreading
  always_comb begin
    for (int j = 0; j < Lanes; j++)
      older[j] = id_i[j].valid && younger(id_i[j].age, cons.age);
  end

  assign stat_o.id_valid   = cons.valid;
  assign stat_o.prim       = cons.valid && st;
  assign stat_o.older_than = older;
endmodule

[rtl/superscalar_hazard_interlock_unit.sv]
`timescale 1ns / 1ps
// Interlock of a two-wide in-order IF/ID/EX/MA pipeline. Each accepted item is one
// processor clock: it offers up to two trace records and yields one result (records
// fetched, decode stall mask, retire count, fetch blocked). One item per cycle: the
// latch update and the result are computed in the accept cycle by per-lane hazard
// checkers and a merge; the result sits in an output register, and the next item is
// taken whenever that register is empty or being drained. Configuration writes are
// taken at any time and apply from the next item.
module superscalar_hazard_interlock_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  shi_in_if.sink      in_i,
  shi_out_if.source   out_o,
  shi_cfg_if.sink     cfg_i
);
  import shi_pkg::*;

  entry_t [Lanes-1:0] if_q, id_q, ex_q, ma_q;
  entry_t [Lanes-1:0] if_d, id_d, ex_d, ma_d;
  entry_t [Lanes-1:0] id_s, ex_s;
  age_t   next_age_q, next_age_d;
  logic   wait_q, wait_d, wait_s;
  logic   mem_fwd_q, exe_fwd_q;
  logic   ovalid_q;
  result_t res_q, res_d;
  lane_stat_t [Lanes-1:0] stat;
  logic [Lanes-1:0] prim, stall;
  logic   take;
  logic   ended;
  logic [CntW-1:0] retired, taken;
  entry_t fe;

  assign in_i.ready  = !ovalid_q || out_o.ready;
  assign take        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Retire, clear mispredict flags, then shift latches
  always_comb begin
    entry_t [Lanes-1:0] ift, idt, ext;
    ift = if_q; idt = id_q; ext = ex_q;
    wait_s = wait_q;
    retired = '0;
    for (int l = 0; l < Lanes; l++) begin
      if (ma_q[l].valid) begin
        if (ma_q[l].misp) begin
          wait_s = 1'b0;
          ext[l].misp = 1'b0;
          idt[l].misp = 1'b0;
          ift[l].misp = 1'b0;
        end
        retired = retired + 1'b1;
      end
    end
    ma_d = ext;
    ex_s = idt;
    for (int l = 0; l < Lanes; l++)
      if (idt[l].stall) ex_s[l].valid = 1'b0;
    id_s = ift;
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    shi_lane u_lane (
      .lane_i   (LaneW'(g)),
      .id_i     (id_s),
      .ex_i     (ex_s),
      .ma_i     (ma_d),
      .mem_fwd_i(mem_fwd_q),
      .exe_fwd_i(exe_fwd_q),
      .stat_o   (stat[g])
    );
  end

  // Merge lane verdicts, spread stalls, fetch in lane order
  always_comb begin
    for (int i = 0; i < Lanes; i++) prim[i] = stat[i].prim;
    stall = prim;
    for (int i = 0; i < Lanes; i++)
      if (prim[i]) stall = stall | stat[i].older_than;
    ex_d = ex_s;
    id_d = id_s;
    if_d = id_s;
    for (int i = 0; i < Lanes; i++)
      if (stall[i]) id_d[i].stall = 1'b1;
    next_age_d = next_age_q;
    wait_d = wait_s;
    taken = '0;
    ended = 1'b0;
    fe = '0;
    for (int l = 0; l < Lanes; l++) begin
      if (!stall[l]) begin
        if (wait_d || ended || !in_i.data.present[taken[LaneW-1:0]]) begin
          if (!wait_d) ended = 1'b1;
          if_d[l].valid = 1'b0;
        end else begin
          fe.valid = 1'b1;
          fe.stall = 1'b0;
          fe.load  = in_i.data.is_load[taken[LaneW-1:0]];
          fe.misp  = in_i.data.misp[taken[LaneW-1:0]];
          fe.src1  = in_i.data.src1_used[taken[LaneW-1:0]];
          fe.src2  = in_i.data.src2_used[taken[LaneW-1:0]];
          fe.dest  = in_i.data.dest_used[taken[LaneW-1:0]];
          fe.ccr   = in_i.data.cc_reads[taken[LaneW-1:0]];
          fe.ccw   = in_i.data.cc_writes[taken[LaneW-1:0]];
          fe.r1    = in_i.data.src1_regs[taken[LaneW-1:0]*8 +: RegBits];
          fe.r2    = in_i.data.src2_regs[taken[LaneW-1:0]*8 +: RegBits];
          fe.rd    = in_i.data.dest_regs[taken[LaneW-1:0]*8 +: RegBits];
          fe.age   = next_age_d;
          if_d[l]  = fe;
          next_age_d = next_age_d + 1'b1;
          if (fe.misp) wait_d = 1'b1;
          taken = taken + 1'b1;
        end
      end
    end
    res_d.records_taken     = 2'(taken);
    res_d.decode_stall_mask = 2'(stall);
    res_d.retired_count     = 2'(retired);
    res_d.fetch_blocked     = wait_d;
  end

  // Advance pipeline state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      if_q <= '0; id_q <= '0; ex_q <= '0; ma_q <= '0;
      next_age_q <= '0;
      wait_q <= 1'b0;
    end else if (take) begin
      if_q <= if_d; id_q <= id_d; ex_q <= ex_d; ma_q <= ma_d;
      next_age_q <= next_age_d;
      wait_q <= wait_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_fwd_q <= 1'b0;
      exe_fwd_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgMemFwd: mem_fwd_q <= cfg_i.wdata;
        CfgExeFwd: exe_fwd_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (take) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data  = res_q;

  a_wait_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (res_q.fetch_blocked == wait_q)) else $error("fetch_blocked mismatch");
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ((res_q.decode_stall_mask & ~{$past(stat[1].id_valid),
      $past(stat[0].id_valid)}) == '0)) else $error("stall on invalid lane");
  a_taken_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (taken <= CntW'(Lanes))) else $error("too many fetched");
endmodule
